// ===== rtl/wsd_pkg.sv =====
// shared types, codes and constants of the websocket deframer
`timescale 1ns / 1ps

package wsd_pkg;

  // fixed field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 4;
  localparam int unsigned LenW    = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned KindW   = 2;
  localparam int unsigned ErrW    = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 32;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // header constants
  localparam logic [6:0]      Len7Ext16   = 7'd126;
  localparam logic [6:0]      Len7Ext64   = 7'd127;
  localparam logic [CountW-1:0] Ext16Bytes = 4'd2;
  localparam logic [CountW-1:0] Ext64Bytes = 4'd8;
  localparam logic [CountW-1:0] KeyBytes   = 4'd4;
  localparam logic [LenW-1:0] CtrlMaxLen  = 32'd126;

  // opcodes of the frame header
  localparam logic [OpW-1:0] OpContinuation   = 4'h0;
  localparam logic [OpW-1:0] OpText           = 4'h1;
  localparam logic [OpW-1:0] OpBinary         = 4'h2;
  localparam logic [OpW-1:0] OpReservedDataLo = 4'h3;
  localparam logic [OpW-1:0] OpReservedDataHi = 4'h7;
  localparam logic [OpW-1:0] OpClose          = 4'h8;
  localparam logic [OpW-1:0] OpPing           = 4'h9;
  localparam logic [OpW-1:0] OpPong           = 4'ha;
  localparam logic [OpW-1:0] OpReservedCtrlLo = 4'hb;
  localparam logic [OpW-1:0] OpReservedCtrlHi = 4'hf;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgClientRole = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload = 1'd1;

  typedef enum logic [2:0] {
    PH_HEAD0,
    PH_HEAD1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [ErrW-1:0] {
    ERR_FRAG_CTRL = 3'd0,
    ERR_CTRL_LONG = 3'd1,
    ERR_MASK      = 3'd2,
    ERR_TOO_BIG   = 3'd3,
    ERR_OPCODE    = 3'd4
  } err_e;

  // configuration seen by the parser
  typedef struct packed {
    logic            client_role;
    logic [LenW-1:0] max_payload;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_e            kind;
    logic [OpW-1:0]   opcode;
    logic             fin;
    logic [LenW-1:0]  length;
    logic [ByteW-1:0] raw_byte;
    logic [ByteW-1:0] key_byte;
    logic             last;
    err_e             err;
  } q_entry_t;

endpackage

// ===== rtl/wsd_intf.sv =====
// channel interfaces: received bytes, results and configuration writes
`timescale 1ns / 1ps

interface wsd_byte_if import wsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if import wsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [OpW-1:0]   frame_opcode;
  logic             fin_flag;
  logic [LenW-1:0]  payload_len;
  logic [ByteW-1:0] data_byte;
  logic             last_of_frame;
  logic [ErrW-1:0]  error_code;

  modport source (output valid, output kind, output frame_opcode, output fin_flag,
                  output payload_len, output data_byte, output last_of_frame,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input frame_opcode, input fin_flag,
                  input payload_len, input data_byte, input last_of_frame,
                  input error_code, output ready);
endinterface

interface wsd_cfg_if import wsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/wsd_front.sv =====
// header parser and payload classifier: one byte per cycle while the queue is not full
`timescale 1ns / 1ps

module wsd_front import wsd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  wsd_byte_if.sink      rx,
  input  cfg_t          cfg_i,
  input  logic          q_full_i,
  output logic          push_o,
  output q_entry_t      entry_o
);

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0]   len_q, len_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic              masked_q, masked_d;
  logic [OpW-1:0]    op_q, op_d;
  logic              fin_q, fin_d;
  logic [LenW-1:0]   size_q, size_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic              failed_q, failed_d;

  logic              accept;
  logic              step;
  logic [ByteW-1:0]  b;
  logic              len7_ext;
  logic              do_len_done;
  logic              do_finish;
  logic [AccW-1:0]   fin_len;
  logic              fin_masked;
  logic              len_hi;
  logic              control;
  logic              hdr_bad;
  err_e              hdr_err;
  logic [CountW-1:0] cnt_dec;
  logic [CountW-1:0] cnt_inc;
  logic [LenW-1:0]   pos_inc;
  logic [ByteW-1:0]  key_sel;

  assign rx.ready = !q_full_i;
  assign accept   = rx.valid && rx.ready;
  assign step     = accept && !failed_q;
  assign b        = rx.rx_byte;
  assign control  = op_q[3];
  assign len7_ext = (b[6:0] == Len7Ext16) || (b[6:0] == Len7Ext64);
  assign cnt_dec  = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
  assign cnt_inc  = cnt_q + 1'b1;
  assign pos_inc  = pos_q + 1'b1;

  // mask key byte for the current payload position, most significant first
  always_comb begin
    case (pos_q[1:0])
      2'd0:    key_sel = key_q[31:24];
      2'd1:    key_sel = key_q[23:16];
      2'd2:    key_sel = key_q[15:8];
      default: key_sel = key_q[7:0];
    endcase
  end

  // length and mask bit as they stand with the current byte taken in
  always_comb begin
    case (phase_q)
      PH_HEAD1:  fin_len = {{(AccW-7){1'b0}}, b[6:0]};
      PH_EXTLEN: fin_len = {len_q[AccW-ByteW-1:0], b};
      default:   fin_len = len_q;
    endcase
  end

  assign fin_masked  = (phase_q == PH_HEAD1) ? b[7] : masked_q;
  assign do_len_done = step && ((phase_q == PH_HEAD1 && !len7_ext) ||
                                (phase_q == PH_EXTLEN && cnt_dec == '0));
  assign do_finish   = (do_len_done && !fin_masked) ||
                       (step && phase_q == PH_KEY && cnt_inc >= KeyBytes);
  assign len_hi      = |fin_len[AccW-1:LenW];

  // header checks, the first fault in order of precedence wins
  always_comb begin
    hdr_bad = 1'b1;
    hdr_err = ERR_FRAG_CTRL;
    if (control && !fin_q) begin
      hdr_err = ERR_FRAG_CTRL;
    end else if (control && (len_hi || fin_len[LenW-1:0] >= CtrlMaxLen)) begin
      hdr_err = ERR_CTRL_LONG;
    end else if (cfg_i.client_role == fin_masked) begin
      hdr_err = ERR_MASK;
    end else if (len_hi || fin_len[LenW-1:0] > cfg_i.max_payload) begin
      hdr_err = ERR_TOO_BIG;
    end else if ((op_q >= OpReservedDataLo && op_q <= OpReservedDataHi) ||
                 op_q >= OpReservedCtrlLo) begin
      hdr_err = ERR_OPCODE;
    end else begin
      hdr_bad = 1'b0;
    end
  end

  // header state machine: next state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    key_d    = key_q;
    masked_d = masked_q;
    op_d     = op_q;
    fin_d    = fin_q;
    size_d   = size_q;
    pos_d    = pos_q;
    failed_d = failed_q;
    if (step) begin
      unique case (phase_q)
        PH_HEAD0: begin
          fin_d   = b[7];
          op_d    = b[OpW-1:0];
          len_d   = '0;
          key_d   = '0;
          cnt_d   = '0;
          phase_d = PH_HEAD1;
        end
        PH_HEAD1: begin
          masked_d = b[7];
          cnt_d    = '0;
          if (len7_ext) begin
            len_d   = '0;
            cnt_d   = (b[6:0] == Len7Ext16) ? Ext16Bytes : Ext64Bytes;
            phase_d = PH_EXTLEN;
          end else begin
            len_d = fin_len;
          end
        end
        PH_EXTLEN: begin
          len_d = fin_len;
          cnt_d = cnt_dec;
        end
        PH_KEY: begin
          key_d = {key_q[KeyW-ByteW-1:0], b};
          cnt_d = cnt_inc;
        end
        PH_PAYLOAD: begin
          pos_d = pos_inc;
          if (pos_inc >= size_q) begin
            phase_d = PH_HEAD0;
          end
        end
        default: begin
          phase_d = PH_HEAD0;
        end
      endcase
      // end of length field: go to key bytes when masked
      if (do_len_done) begin
        cnt_d = '0;
        if (fin_masked) begin
          phase_d = PH_KEY;
        end
      end
      // header complete: stop on a fault, else start the payload
      if (do_finish) begin
        if (hdr_bad) begin
          failed_d = 1'b1;
        end else begin
          size_d  = fin_len[LenW-1:0];
          pos_d   = '0;
          cnt_d   = '0;
          phase_d = (fin_len[LenW-1:0] == '0) ? PH_HEAD0 : PH_PAYLOAD;
        end
      end
    end
  end

  // item pushed into the queue
  always_comb begin
    push_o           = 1'b0;
    entry_o.kind     = KIND_HEADER;
    entry_o.opcode   = op_q;
    entry_o.fin      = fin_q;
    entry_o.length   = size_q;
    entry_o.raw_byte = '0;
    entry_o.key_byte = '0;
    entry_o.last     = 1'b0;
    entry_o.err      = ERR_FRAG_CTRL;
    if (do_finish) begin
      push_o = 1'b1;
      if (hdr_bad) begin
        entry_o.kind   = KIND_ERROR;
        entry_o.err    = hdr_err;
        entry_o.length = '0;
      end else begin
        entry_o.kind   = KIND_HEADER;
        entry_o.length = fin_len[LenW-1:0];
        entry_o.last   = (fin_len[LenW-1:0] == '0);
      end
    end else if (step && phase_q == PH_PAYLOAD) begin
      push_o           = 1'b1;
      entry_o.kind     = KIND_PAYLOAD;
      entry_o.raw_byte = b;
      entry_o.key_byte = masked_q ? key_sel : '0;
      entry_o.last     = (pos_inc >= size_q);
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEAD0;
      cnt_q    <= '0;
      len_q    <= '0;
      key_q    <= '0;
      masked_q <= 1'b0;
      op_q     <= '0;
      fin_q    <= 1'b0;
      size_q   <= '0;
      pos_q    <= '0;
      failed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      key_q    <= key_d;
      masked_q <= masked_d;
      op_q     <= op_d;
      fin_q    <= fin_d;
      size_q   <= size_d;
      pos_q    <= pos_d;
      failed_q <= failed_d;
    end
  end

`ifndef ASSERT_OFF
  // once failed, the parser stays failed until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) failed_q |=> failed_q)
    else $error("failed flag cleared without reset");
  // nothing reaches the queue after an error
  assert property (@(posedge clk_i) disable iff (!rst_ni) failed_q |-> !push_o)
    else $error("item pushed after error");
  // a payload item is only produced for a non-empty frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (phase_q == PH_PAYLOAD) |-> (size_q != '0))
    else $error("payload phase with empty frame");
`endif

endmodule

// ===== rtl/wsd_fifo.sv =====
// short queue of classified items between parser and output stage
`timescale 1ns / 1ps

module wsd_fifo import wsd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output q_entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == DepthCnt);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  // the parser never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");
  // fill count stays within depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("queue count overflow");
  // the queue is never full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(full_o && empty_o))
    else $error("queue full and empty together");
`endif

endmodule

// ===== rtl/wsd_back.sv =====
// output stage: unmasks payload bytes and holds the result for the sink
`timescale 1ns / 1ps

module wsd_back import wsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  q_entry_t  q_data_i,
  output logic      pop_o,
  wsd_res_if.source res
);

  logic             valid_q;
  kind_e            kind_q;
  logic [OpW-1:0]   op_q;
  logic             fin_q;
  logic [LenW-1:0]  len_q;
  logic [ByteW-1:0] data_q;
  logic             last_q;
  err_e             err_q;
  logic             load;

  assign load  = !q_empty_i && (!valid_q || res.ready);
  assign pop_o = load;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (res.ready) begin
      valid_q <= 1'b0;
    end
  end

  // result register, payload bytes unmasked on the way in
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= q_data_i.kind;
      op_q   <= q_data_i.opcode;
      fin_q  <= q_data_i.fin;
      len_q  <= q_data_i.length;
      data_q <= q_data_i.raw_byte ^ q_data_i.key_byte;
      last_q <= q_data_i.last;
      err_q  <= (q_data_i.kind == KIND_ERROR) ? q_data_i.err : ERR_FRAG_CTRL;
    end
  end

  assign res.valid         = valid_q;
  assign res.kind          = kind_q;
  assign res.frame_opcode  = op_q;
  assign res.fin_flag      = fin_q;
  assign res.payload_len   = len_q;
  assign res.data_byte     = data_q;
  assign res.last_of_frame = last_q;
  assign res.error_code    = err_q;

endmodule

// ===== rtl/websocket_frame_deframer_unit.sv =====
// websocket frame deframer top level: config registers, parser, queue, output stage
// a taken byte is written into the queue, then loaded into the result register and
// held until the sink takes it; inner header bytes give no result
// throughput: one received byte per cycle; input stalls only when the queue (two
// entries by default) is full behind a held result
// reset: asynchronous, active low; parser waits for a first header byte,
// client_role clears and max_payload sets to all ones
`timescale 1ns / 1ps

module websocket_frame_deframer_unit import wsd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wsd_byte_if.sink  rx_i,
  wsd_cfg_if.sink   cfg_i,
  wsd_res_if.source res_o
);

  cfg_t     cfg_q;
  logic     q_full, q_empty, push, pop;
  q_entry_t push_data, pop_data;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.client_role <= 1'b0;
      cfg_q.max_payload <= '1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgClientRole: cfg_q.client_role <= cfg_i.data[0];
        CfgMaxPayload: cfg_q.max_payload <= cfg_i.data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // parser front
  wsd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx       (rx_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_data)
  );

  // queue between front and back
  wsd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  // output back
  wsd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (pop_data),
    .pop_o     (pop),
    .res       (res_o)
  );

endmodule
